// File: design/ced_pkg.sv
// ----------------------------------------------------------------------------
// ced_pkg: shared types, codes and helpers of the escape sequence decoder
// Holds the decoder mode encoding, the decoder state record, the per-byte
// result record and the character constants used by the decode logic.
// ----------------------------------------------------------------------------
package ced_pkg;

    // decoder mode
    typedef enum logic [2:0] {
        MODE_NORMAL    = 3'd0,
        MODE_ESC       = 3'd1,
        MODE_HEX_START = 3'd2,
        MODE_HEX       = 3'd3,
        MODE_OCT       = 3'd4
    } t_mode;

    // full decoder state carried between bytes
    typedef struct packed {
        t_mode       mode;
        logic [7:0]  acc;
        logic [1:0]  oct_cnt;
        logic [6:0]  hex_bits;
        logic        hex_sat;
    } t_dec_state;

    // decoded bytes caused by one input byte
    typedef struct packed {
        logic [1:0]  count;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
    } t_dec_result;

    // hex values above this many significant bits saturate to all ones
    localparam logic [6:0] HEX_LIMIT_BITS = 7'd63;
    localparam logic [6:0] HEX_SAT_BITS   = 7'd64;
    localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_X   = 8'h78;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LC_AF  = 8'h66;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;

    localparam logic [7:0] CODE_TAB  = 8'd9;
    localparam logic [7:0] CODE_BEL  = 8'd7;
    localparam logic [7:0] CODE_LF   = 8'd10;
    localparam logic [7:0] CODE_FF   = 8'd12;
    localparam logic [7:0] CODE_CR   = 8'd13;
    localparam logic [7:0] CODE_ONES = 8'hFF;

    // true for 0-9, a-f, A-F
    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
               ((c >= CH_LC_A) && (c <= CH_LC_AF)) ||
               ((c >= CH_UC_A) && (c <= CH_UC_F));
    endfunction

    // nibble value of a hex digit
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            v = c - CH_ZERO;
        end else if ((c >= CH_LC_A) && (c <= CH_LC_AF)) begin
            v = c - CH_LC_A + 8'd10;
        end else begin
            v = c - CH_UC_A + 8'd10;
        end
        return v[3:0];
    endfunction

    function automatic logic is_octal(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_SEVEN);
    endfunction

    // number of significant bits in a nibble
    function automatic logic [6:0] bit_length4(input logic [3:0] d);
        logic [6:0] n;
        if (d[3]) begin
            n = 7'd4;
        end else if (d[2]) begin
            n = 7'd3;
        end else if (d[1]) begin
            n = 7'd2;
        end else if (d[0]) begin
            n = 7'd1;
        end else begin
            n = 7'd0;
        end
        return n;
    endfunction

endpackage

// File: design/ced_in_if.sv
// ----------------------------------------------------------------------------
// ced_in_if: input channel of the escape sequence decoder
// One escaped string byte per transaction, with a flag on the final byte.
// ----------------------------------------------------------------------------
interface ced_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// File: design/ced_out_if.sv
// ----------------------------------------------------------------------------
// ced_out_if: output channel of the escape sequence decoder
// One decoded byte per transaction, with end-of-run and end-of-string flags.
// ----------------------------------------------------------------------------
interface ced_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;

    modport source (output valid, output out_byte, output run_last,
                    output string_end, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input string_end, output ready);
endinterface

// File: design/c_escape_sequence_decoder.sv
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder: streaming C escape sequence decoder
// Decodes backslash escapes (control codes, hex and octal values) from an
// escaped byte stream and delivers the decoded bytes one per transaction.
//
//   channel | dir | payload                          | meaning
//   --------+-----+----------------------------------+------------------------
//   i_in    | in  | in_byte[7:0], last_byte          | escaped string bytes
//   o_out   | out | out_byte[7:0], run_last,         | decoded bytes
//           |     | string_end                       |
//
// An input byte is decoded in the cycle it is taken; its results appear in
// the output register on the next cycle. Bytes causing zero or one result
// are taken every cycle; a byte causing two results (flushed hex/octal value
// plus a byte) parks its second result in a pending register, so the next
// input waits for it to drain. Output stalls hold the output and
// pending registers and stop input. Reset (synchronous) returns the decoder
// to normal mode and empties both registers.
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder
    import ced_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ced_in_if.sink     i_in,
    ced_out_if.source  o_out
);

    t_dec_state  r_state;
    t_dec_state  n_state;
    t_dec_result dec_res;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_run_last;
    logic        r_out_end;
    logic        r_pend_valid;
    logic [7:0]  r_pend_byte;
    logic        r_pend_end;

    logic        in_take;
    logic        out_take;

    ced_decode u_decode (
        .i_state  (r_state),
        .i_byte   (i_in.in_byte),
        .i_last   (i_in.last_byte),
        .o_state  (n_state),
        .o_result (dec_res)
    );

    assign out_take    = r_out_valid && o_out.ready;
    assign i_in.ready  = !r_pend_valid && (!r_out_valid || o_out.ready);
    assign in_take     = i_in.valid && i_in.ready;

    // advance the decoder state on each input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode     <= MODE_NORMAL;
            r_state.acc      <= 8'd0;
            r_state.oct_cnt  <= 2'd0;
            r_state.hex_bits <= 7'd0;
            r_state.hex_sat  <= 1'b0;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // load fresh results, otherwise drain the pending result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (in_take && (dec_res.count != 2'd0)) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= (dec_res.count == 2'd2);
            end else if (out_take) begin
                r_out_valid  <= r_pend_valid;
                r_pend_valid <= 1'b0;
            end
        end
    end

    // output and pending payload
    always_ff @(posedge i_clk) begin
        if (out_take && r_pend_valid) begin
            r_out_byte     <= r_pend_byte;
            r_out_run_last <= 1'b1;
            r_out_end      <= r_pend_end;
        end
        if (in_take && (dec_res.count != 2'd0)) begin
            r_out_byte     <= dec_res.byte0;
            r_out_run_last <= (dec_res.count == 2'd1);
            r_out_end      <= (dec_res.count == 2'd1) && i_in.last_byte;
            r_pend_byte    <= dec_res.byte1;
            r_pend_end     <= i_in.last_byte;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_byte   = r_out_byte;
    assign o_out.run_last   = r_out_run_last;
    assign o_out.string_end = r_out_end;

endmodule

// File: design/ced_decode.sv
// ----------------------------------------------------------------------------
// ced_decode: single-byte decode step
// From the current decoder state and one input byte, computes the next state
// and the zero, one or two decoded bytes that the input byte causes.
// ----------------------------------------------------------------------------
module ced_decode
    import ced_pkg::*;
(
    input  t_dec_state  i_state,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output t_dec_state  o_state,
    output t_dec_result o_result
);

    logic       hex_ok;
    logic [3:0] hex_d;
    logic       oct_ok;
    logic [2:0] oct_d;
    logic [7:0] hex_out;
    logic       do_plain;

    assign hex_ok  = is_hex(i_byte);
    assign hex_d   = hex_nibble(i_byte);
    assign oct_ok  = is_octal(i_byte);
    assign oct_d   = i_byte[2:0];
    assign hex_out = i_state.hex_sat ? CODE_ONES : i_state.acc;

    // decode one byte
    always_comb begin
        t_dec_state  nxt;
        t_dec_result res;
        logic [6:0]  bits;
        logic [1:0]  ocnt;

        nxt       = i_state;
        res.count = 2'd0;
        res.byte0 = 8'd0;
        res.byte1 = 8'd0;
        do_plain  = 1'b0;
        bits      = 7'd0;
        ocnt      = 2'd0;

        case (i_state.mode)
            MODE_ESC: begin
                nxt.mode  = MODE_NORMAL;
                res.count = 2'd1;
                case (i_byte)
                    CH_BSLASH: res.byte0 = CH_BSLASH;
                    CH_LC_T:   res.byte0 = CODE_TAB;
                    CH_LC_A:   res.byte0 = CODE_BEL;
                    CH_LC_N:   res.byte0 = CODE_LF;
                    CH_LC_F:   res.byte0 = CODE_FF;
                    CH_LC_R:   res.byte0 = CODE_CR;
                    CH_LC_X: begin
                        nxt.mode  = MODE_HEX_START;
                        res.byte0 = CH_LC_X;
                        res.count = {1'b0, i_last};
                    end
                    default: begin
                        if (oct_ok) begin
                            nxt.mode    = MODE_OCT;
                            nxt.acc     = {5'd0, oct_d};
                            nxt.oct_cnt = 2'd1;
                            res.byte0   = {5'd0, oct_d};
                            res.count   = {1'b0, i_last};
                        end else begin
                            res.byte0 = i_byte;
                        end
                    end
                endcase
            end
            MODE_HEX_START: begin
                if (hex_ok) begin
                    nxt.mode     = MODE_HEX;
                    nxt.acc      = {4'd0, hex_d};
                    nxt.hex_bits = bit_length4(hex_d);
                    nxt.hex_sat  = 1'b0;
                    res.byte0    = {4'd0, hex_d};
                    res.count    = {1'b0, i_last};
                end else begin
                    res.byte0 = CH_LC_X;
                    res.count = 2'd1;
                    do_plain  = 1'b1;
                end
            end
            MODE_HEX: begin
                if (hex_ok) begin
                    nxt.acc = {i_state.acc[3:0], hex_d};
                    if (!i_state.hex_sat) begin
                        bits = (i_state.hex_bits == 7'd0) ? bit_length4(hex_d)
                                                          : i_state.hex_bits + 7'd4;
                        if (bits > HEX_LIMIT_BITS) begin
                            nxt.hex_sat  = 1'b1;
                            nxt.hex_bits = HEX_SAT_BITS;
                        end else begin
                            nxt.hex_bits = bits;
                        end
                    end
                    res.byte0 = nxt.hex_sat ? CODE_ONES : nxt.acc;
                    res.count = {1'b0, i_last};
                end else begin
                    res.byte0 = hex_out;
                    res.count = 2'd1;
                    do_plain  = 1'b1;
                end
            end
            MODE_OCT: begin
                if (oct_ok) begin
                    nxt.acc     = {i_state.acc[4:0], oct_d};
                    ocnt        = i_state.oct_cnt + 2'd1;
                    nxt.oct_cnt = ocnt;
                    res.byte0   = {i_state.acc[4:0], oct_d};
                    if (ocnt >= OCT_MAX_DIGITS) begin
                        nxt.mode  = MODE_NORMAL;
                        res.count = 2'd1;
                    end else begin
                        res.count = {1'b0, i_last};
                    end
                end else begin
                    res.byte0 = i_state.acc;
                    res.count = 2'd1;
                    do_plain  = 1'b1;
                end
            end
            default: begin
                do_plain = 1'b1;
            end
        endcase

        // handle the byte outside any escape, after a flushed value if any
        if (do_plain) begin
            if (i_byte == CH_BSLASH) begin
                nxt.mode = MODE_ESC;
                if (i_last) begin
                    if (res.count == 2'd0) begin
                        res.byte0 = CH_BSLASH;
                    end else begin
                        res.byte1 = CH_BSLASH;
                    end
                    res.count = res.count + 2'd1;
                end
            end else begin
                nxt.mode = MODE_NORMAL;
                if (res.count == 2'd0) begin
                    res.byte0 = i_byte;
                end else begin
                    res.byte1 = i_byte;
                end
                res.count = res.count + 2'd1;
            end
        end

        // drop the numeric context outside hex/octal runs and at string end
        if ((nxt.mode == MODE_NORMAL) || i_last) begin
            nxt.acc      = 8'd0;
            nxt.oct_cnt  = 2'd0;
            nxt.hex_bits = 7'd0;
            nxt.hex_sat  = 1'b0;
        end
        if (i_last) begin
            nxt.mode = MODE_NORMAL;
        end

        o_state  = nxt;
        o_result = res;
    end

endmodule

// File: design/ced_checker.sv
// ----------------------------------------------------------------------------
// ced_checker: port-level checks of the escape sequence decoder
// Watches the top-level channels and flags reset, handshake and flag errors.
// ----------------------------------------------------------------------------
module ced_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_last,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_run_last,
    input logic       i_out_end
);

    // no output transaction right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a final input byte always yields at least one result next cycle
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last) |=> i_out_valid)
        else $error("final byte produced no result");

    // end of string only on the last result of a run
    a_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_end) |-> i_out_run_last)
        else $error("string_end without run_last");

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_byte) && $stable(i_out_end)))
        else $error("stalled output changed");

endmodule

bind c_escape_sequence_decoder ced_checker u_ced_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_last      (i_in.last_byte),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_byte     (o_out.out_byte),
    .i_out_run_last (o_out.run_last),
    .i_out_end      (o_out.string_end)
);

// File: tb/c_escape_sequence_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder_tb: self-checking bench of the escape decoder
// Feeds escaped strings through the input channel, predicts the decoded bytes
// with a local copy of the decode state, and compares every output
// transaction field by field in order. Directed strings cover control escapes,
// hex and octal flushing, bare escapes and hex saturation; random strings
// follow under several ready/valid idling mixes and a long output stall.
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder_tb;
    import ced_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int LONG_HOLD     = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 10;
    localparam int RANDOM_ITEMS  = 440;

    // one decoded byte as seen on the output channel
    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       str_end;
    } t_decoded;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // bench-side drivers of the channel inputs
    logic       src_valid = 1'b0;
    logic [7:0] src_byte  = 8'h00;
    logic       src_last  = 1'b0;
    logic       snk_ready = 1'b0;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_req     = 0;
    int hold_ack     = 0;
    int hold_left    = 0;
    int err_count    = 0;
    int quiet_cycles = 0;
    int items_sent   = 0;

    // predicted decoder state
    t_mode      st_mode = MODE_NORMAL;
    logic [7:0] st_acc  = 8'h00;
    logic [1:0] st_oct  = 2'd0;
    logic [6:0] st_bits = 7'd0;
    logic       st_sat  = 1'b0;

    logic [7:0] run_bytes[$];
    logic [7:0] str_buf[$];
    t_decoded   decoded_q[$];

    ced_in_if  in_if();
    ced_out_if out_if();

    assign in_if.valid     = src_valid;
    assign in_if.in_byte   = src_byte;
    assign in_if.last_byte = src_last;
    assign out_if.ready    = snk_ready;

    c_escape_sequence_decoder uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // nibble value of a hex digit, -1 for anything else
    function automatic int hex_digit(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return int'(c - CH_ZERO);
        end
        if (c >= CH_LC_A && c <= CH_LC_AF) begin
            return int'(c - CH_LC_A) + 10;
        end
        if (c >= CH_UC_A && c <= CH_UC_F) begin
            return int'(c - CH_UC_A) + 10;
        end
        return -1;
    endfunction

    function automatic logic octal_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_SEVEN);
    endfunction

    // shift a hex digit in and track the significant bit count
    function void hex_shift_in(input int d);
        logic [6:0] len;
        st_acc = {st_acc[3:0], 4'(d)};
        if (!st_sat) begin
            if (d >= 8) begin
                len = 7'd4;
            end else if (d >= 4) begin
                len = 7'd3;
            end else if (d >= 2) begin
                len = 7'd2;
            end else begin
                len = 7'(d);
            end
            st_bits = (st_bits == 7'd0) ? len : st_bits + 7'd4;
            if (st_bits > HEX_LIMIT_BITS) begin
                st_sat  = 1'b1;
                st_bits = HEX_SAT_BITS;
            end
        end
    endfunction

    function logic [7:0] hex_value_out();
        return st_sat ? CODE_ONES : st_acc;
    endfunction

    // byte outside any escape
    function void unescaped_byte(input logic [7:0] c, input logic last);
        if (c == CH_BSLASH) begin
            st_mode = MODE_ESC;
            if (last) begin
                run_bytes.push_back(CH_BSLASH);
            end
        end else begin
            st_mode = MODE_NORMAL;
            run_bytes.push_back(c);
        end
    endfunction

    // advance the predicted state by one byte and queue the decoded bytes
    function void decode_byte(input logic [7:0] c, input logic last);
        int       hv;
        t_decoded d;
        hv = hex_digit(c);
        run_bytes.delete();
        case (st_mode)
            MODE_ESC: begin
                st_mode = MODE_NORMAL;
                if (c == CH_BSLASH) begin
                    run_bytes.push_back(CH_BSLASH);
                end else if (c == CH_LC_T) begin
                    run_bytes.push_back(CODE_TAB);
                end else if (c == CH_LC_A) begin
                    run_bytes.push_back(CODE_BEL);
                end else if (c == CH_LC_N) begin
                    run_bytes.push_back(CODE_LF);
                end else if (c == CH_LC_F) begin
                    run_bytes.push_back(CODE_FF);
                end else if (c == CH_LC_R) begin
                    run_bytes.push_back(CODE_CR);
                end else if (c == CH_LC_X) begin
                    st_mode = MODE_HEX_START;
                    if (last) begin
                        run_bytes.push_back(CH_LC_X);
                    end
                end else if (octal_digit(c)) begin
                    st_mode = MODE_OCT;
                    st_acc  = c - CH_ZERO;
                    st_oct  = 2'd1;
                    if (last) begin
                        run_bytes.push_back(st_acc);
                    end
                end else begin
                    run_bytes.push_back(c);
                end
            end
            MODE_HEX_START: begin
                if (hv >= 0) begin
                    st_acc  = 8'h00;
                    st_bits = 7'd0;
                    st_sat  = 1'b0;
                    hex_shift_in(hv);
                    st_mode = MODE_HEX;
                    if (last) begin
                        run_bytes.push_back(hex_value_out());
                    end
                end else begin
                    run_bytes.push_back(CH_LC_X);
                    unescaped_byte(c, last);
                end
            end
            MODE_HEX: begin
                if (hv >= 0) begin
                    hex_shift_in(hv);
                    if (last) begin
                        run_bytes.push_back(hex_value_out());
                    end
                end else begin
                    run_bytes.push_back(hex_value_out());
                    unescaped_byte(c, last);
                end
            end
            MODE_OCT: begin
                if (octal_digit(c)) begin
                    st_acc = (st_acc << 3) + (c - CH_ZERO);
                    st_oct = st_oct + 2'd1;
                    if (st_oct >= OCT_MAX_DIGITS) begin
                        run_bytes.push_back(st_acc);
                        st_mode = MODE_NORMAL;
                    end else if (last) begin
                        run_bytes.push_back(st_acc);
                    end
                end else begin
                    run_bytes.push_back(st_acc);
                    unescaped_byte(c, last);
                end
            end
            default: begin
                unescaped_byte(c, last);
            end
        endcase

        // drop the accumulator outside hex/octal runs and at string end
        if (st_mode == MODE_NORMAL || last) begin
            st_acc  = 8'h00;
            st_oct  = 2'd0;
            st_bits = 7'd0;
            st_sat  = 1'b0;
        end
        if (last) begin
            st_mode = MODE_NORMAL;
        end

        foreach (run_bytes[k]) begin
            d.data     = run_bytes[k];
            d.run_last = (k == run_bytes.size() - 1);
            d.str_end  = d.run_last && last;
            decoded_q.push_back(d);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Output side: ready pattern with an occasional long hold-off
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            snk_ready <= 1'b0;
        end else if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= LONG_HOLD;
            snk_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            snk_ready <= 1'b0;
        end else begin
            snk_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Compare each output transaction with the oldest prediction
    always @(posedge clk) begin
        t_decoded exp_d;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected output: actual byte %02h run_last %0b string_end %0b",
                         $time, out_if.out_byte, out_if.run_last, out_if.string_end);
                err_count++;
            end else begin
                exp_d = decoded_q.pop_front();
                if (out_if.out_byte !== exp_d.data) begin
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $time, exp_d.data, out_if.out_byte);
                    err_count++;
                end
                if (out_if.run_last !== exp_d.run_last) begin
                    $display("%0t: run_last mismatch: expected %0b, actual %0b",
                             $time, exp_d.run_last, out_if.run_last);
                    err_count++;
                end
                if (out_if.string_end !== exp_d.str_end) begin
                    $display("%0t: string_end mismatch: expected %0b, actual %0b",
                             $time, exp_d.str_end, out_if.string_end);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("c_escape_sequence_decoder regression: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // offer one byte, hold it until taken, then predict its output
    task automatic send_byte(input logic [7:0] c, input logic last);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            src_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        src_valid <= 1'b1;
        src_byte  <= c;
        src_last  <= last;
        do @(posedge clk); while (!in_if.ready);
        decode_byte(c, last);
        items_sent++;
    endtask

    // send the buffered string, flagging its final byte
    task automatic send_buffer();
        foreach (str_buf[i]) begin
            send_byte(str_buf[i], i == str_buf.size() - 1);
        end
        str_buf.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            str_buf.push_back(s[i]);
        end
        send_buffer();
    endtask

    // hold the input until every predicted byte has come out
    task automatic wait_drain();
        src_valid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) begin
            return CH_ZERO + 8'(v);
        end
        return ($urandom_range(1) ? CH_LC_A : CH_UC_A) + 8'(v - 10);
    endfunction

    function automatic logic [7:0] octal_char();
        return CH_ZERO + 8'($urandom_range(7));
    endfunction

    // append \x and a hex run; optional leading zeros
    function automatic void push_hex_run(input int lead0, input int first, input int tail);
        str_buf.push_back(CH_BSLASH);
        str_buf.push_back(CH_LC_X);
        repeat (lead0) str_buf.push_back(CH_ZERO);
        if (first >= 0) begin
            str_buf.push_back(hex_char(first));
        end
        repeat (tail) str_buf.push_back(hex_char($urandom_range(15)));
    endfunction

    // append one random token: mostly well-formed escapes, some noise
    function automatic void push_token();
        logic [7:0] simple_esc[6];
        int         k;
        int         r;
        simple_esc = '{CH_BSLASH, CH_LC_T, CH_LC_A, CH_LC_N, CH_LC_F, CH_LC_R};
        k = $urandom_range(99);
        if (k < 30) begin
            str_buf.push_back(8'($urandom_range(255, 1)));
        end else if (k < 45) begin
            str_buf.push_back(CH_BSLASH);
            str_buf.push_back(simple_esc[$urandom_range(5)]);
        end else if (k < 65) begin
            r = $urandom_range(9);
            if (r == 0) begin
                push_hex_run(0, -1, 0);
            end else if (r < 8) begin
                push_hex_run(($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0,
                             $urandom_range(15), $urandom_range(2));
            end else begin
                push_hex_run($urandom_range(1), $urandom_range(15, 1),
                             $urandom_range(16, 13));
            end
        end else if (k < 85) begin
            str_buf.push_back(CH_BSLASH);
            repeat ($urandom_range(4, 1)) str_buf.push_back(octal_char());
        end else if (k < 95) begin
            str_buf.push_back(CH_BSLASH);
            str_buf.push_back(8'($urandom_range(255, 1)));
        end else begin
            str_buf.push_back(CH_BSLASH);
        end
    endfunction

    task automatic send_random_strings(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            repeat ($urandom_range(8, 1)) push_token();
            send_buffer();
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_plain_extremes();
        send_text("\001\377\200\177");
    endtask

    task automatic test_control_escapes();
        send_text("\\t\\a\\n\\f\\r\\\\");
    endtask

    // "0x" after \x: the x ends the hex run and passes through
    task automatic test_hex_prefix();
        send_text("\\x0x");
    endtask

    // three octal digits flush at once, the fourth is an ordinary byte
    task automatic test_octal_limit();
        send_text("\\1234");
    endtask

    // \x with no digit, then a trailing backslash on the final byte
    task automatic test_bare_escapes();
        send_text("\\x\\");
    endtask

    // runs around 63 significant bits, with and without a terminator
    task automatic test_hex_saturation();
        for (int i = 0; i < 8; i++) begin
            push_hex_run(i % 3, (i % 2 == 0) ? 7 : 8, 15 + (i / 4));
            if (i % 2 == 1) begin
                str_buf.push_back(8'($urandom_range(255, 1)));
            end
            send_buffer();
        end
    endtask

    // long output stall with the input kept busy, then a full drain
    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req <= hold_req + 1;
        send_random_strings(80);
        wait_drain();
    endtask

    task automatic test_random(input int src_pct, input int snk_pct);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        send_random_strings(RANDOM_ITEMS);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_extremes();
        test_control_escapes();
        test_hex_prefix();
        test_octal_limit();
        test_bare_escapes();
        test_hex_saturation();
        test_backpressure();
        test_random(9, 75);
        test_random(75, 9);
        test_random(0, 0);

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0) begin
            $display("c_escape_sequence_decoder regression: pass");
        end else begin
            $display("c_escape_sequence_decoder regression: fail");
        end
        $finish;
    end

endmodule
